### rtl/json_string_unescaper_core_macros.svh
// ============================================================================
// JSON string unescaper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef JSON_STRING_UNESCAPER_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jsu_pkg.sv
// ============================================================================
// JSON string unescaper package
// Shared types, constants and decode helpers for the unescaper blocks.
// ============================================================================
package jsu_pkg;

  // Width of the length counter; the reported length saturates at
  // the smaller of 2^LENGTH_BITS-1 and the 16-bit field maximum.
  localparam int LENGTH_BITS = 16;
  localparam int LEN_W       = 16;
  localparam logic [LEN_W-1:0] LEN_MAX =
    (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  // Job queue between the parser and the result sequencer.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Maximum results per input word, and the bits that count them.
  localparam int MAX_RES = 3;
  localparam int RES_W   = 2;

  // UTF-8 constants.
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [5:0]  UTF8_MASK  = 6'h3F;
  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;

  // Character codes.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_QUOTE     = 3'd0,
    ERR_BAD_ESCAPE   = 3'd1,
    ERR_SHORT_UNI    = 3'd2,
    ERR_BAD_HEX      = 3'd3,
    ERR_UNTERMINATED = 3'd4
  } err_t;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  // One queued job: the results caused by one input word.
  typedef struct packed {
    logic [RES_W-1:0]        cnt;
    kind_t                   kind;
    err_t                    err;
    logic [LEN_W-1:0]        len;
    logic [MAX_RES-1:0][7:0] bytes;
  } job_t;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Simple escape letter decode: bit 8 is the valid flag.
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE:     r = {1'b1, CH_QUOTE};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      CH_SLASH:     r = {1'b1, CH_SLASH};
      8'h62:        r = {1'b1, 8'h08};  // b
      8'h66:        r = {1'b1, 8'h0C};  // f
      8'h6E:        r = {1'b1, 8'h0A};  // n
      8'h72:        r = {1'b1, 8'h0D};  // r
      8'h74:        r = {1'b1, 8'h09};  // t
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/jsu_channels.sv
// ============================================================================
// JSON string unescaper channels
// Valid/ready interfaces for the input word stream and the result stream.
// ============================================================================

// Input word: one string character or an end-of-input marker.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Result word: decoded byte, completion or error.
interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [2:0]  error_code;
  logic [15:0] decoded_length;
  logic        last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output decoded_length, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input decoded_length, input last, output ready);
endinterface

### rtl/jsu_front.sv
// ============================================================================
// JSON string unescaper front end
// Accepts input words, runs the string parser and packs the results of each
// word into one job for the queue.
// ============================================================================
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  jsu_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output jsu_pkg::job_t job
);

  jsu_pkg::phase_t              phase_r, phase_nxt;
  logic [15:0]                  cp_r, cp_nxt;
  logic [1:0]                   hc_r, hc_nxt;
  logic [jsu_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic                         fire;
  logic [7:0]                   c;
  logic                         eoi;
  logic [4:0]                   hex;
  logic [8:0]                   esc;
  logic [15:0]                  cp_new;
  logic [jsu_pkg::LEN_W+1:0]    len_sum;

  // A word is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign eoi         = in_ch.end_of_input;
  assign hex         = jsu_pkg::hex_digit(c);
  assign esc         = jsu_pkg::esc_map(c);
  assign cp_new      = {cp_r[11:0], hex[3:0]};

  // Parser step: next state and the job for this word.
  always_comb begin
    phase_nxt = phase_r;
    cp_nxt    = cp_r;
    hc_nxt    = hc_r;
    job       = '0;
    job.kind  = jsu_pkg::KIND_BYTE;
    job.err   = jsu_pkg::ERR_NO_QUOTE;
    case (phase_r)
      jsu_pkg::PH_BODY: begin
        if (eoi) begin
          job.cnt   = 2'd1;
          job.kind  = jsu_pkg::KIND_ERR;
          job.err   = jsu_pkg::ERR_UNTERMINATED;
          phase_nxt = jsu_pkg::PH_WAIT;
          cp_nxt    = '0;
          hc_nxt    = '0;
        end else if (c == jsu_pkg::CH_QUOTE) begin
          job.cnt   = 2'd1;
          job.kind  = jsu_pkg::KIND_DONE;
          job.len   = len_r;
          phase_nxt = jsu_pkg::PH_WAIT;
        end else if (c == jsu_pkg::CH_BACKSLASH) begin
          phase_nxt = jsu_pkg::PH_ESC;
        end else begin
          job.cnt      = 2'd1;
          job.bytes[0] = c;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (eoi || (!esc[8] && c != jsu_pkg::CH_LOWER_U)) begin
          job.cnt   = 2'd1;
          job.kind  = jsu_pkg::KIND_ERR;
          job.err   = jsu_pkg::ERR_BAD_ESCAPE;
          phase_nxt = jsu_pkg::PH_WAIT;
          cp_nxt    = '0;
          hc_nxt    = '0;
        end else if (c == jsu_pkg::CH_LOWER_U) begin
          phase_nxt = jsu_pkg::PH_HEX;
          cp_nxt    = '0;
          hc_nxt    = '0;
        end else begin
          job.cnt      = 2'd1;
          job.bytes[0] = esc[7:0];
          phase_nxt    = jsu_pkg::PH_BODY;
        end
      end
      jsu_pkg::PH_HEX: begin
        if (eoi || !hex[4]) begin
          job.cnt   = 2'd1;
          job.kind  = jsu_pkg::KIND_ERR;
          job.err   = eoi ? jsu_pkg::ERR_SHORT_UNI : jsu_pkg::ERR_BAD_HEX;
          phase_nxt = jsu_pkg::PH_WAIT;
          cp_nxt    = '0;
          hc_nxt    = '0;
        end else if (hc_r != 2'd3) begin
          cp_nxt = cp_new;
          hc_nxt = hc_r + 2'd1;
        end else begin
          // Fourth digit: encode the code point as UTF-8.
          phase_nxt = jsu_pkg::PH_BODY;
          cp_nxt    = '0;
          hc_nxt    = '0;
          if (cp_new < jsu_pkg::UTF8_ONE_LIMIT) begin
            job.cnt      = 2'd1;
            job.bytes[0] = cp_new[7:0];
          end else if (cp_new < jsu_pkg::UTF8_TWO_LIMIT) begin
            job.cnt      = 2'd2;
            job.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_new[10:6]};
            job.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp_new[5:0] & jsu_pkg::UTF8_MASK};
          end else begin
            job.cnt      = 2'd3;
            job.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp_new[15:12]};
            job.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp_new[11:6] & jsu_pkg::UTF8_MASK};
            job.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, cp_new[5:0] & jsu_pkg::UTF8_MASK};
          end
        end
      end
      default: begin
        if (!eoi && c == jsu_pkg::CH_QUOTE) begin
          phase_nxt = jsu_pkg::PH_BODY;
          cp_nxt    = '0;
          hc_nxt    = '0;
        end else begin
          job.cnt   = 2'd1;
          job.kind  = jsu_pkg::KIND_ERR;
          job.err   = jsu_pkg::ERR_NO_QUOTE;
          phase_nxt = jsu_pkg::PH_WAIT;
          cp_nxt    = '0;
          hc_nxt    = '0;
        end
      end
    endcase
  end

  // Length counter: cleared on an opening quote, saturating add of bytes.
  always_comb begin
    len_sum = {2'b00, len_r} + {{jsu_pkg::LEN_W{1'b0}}, job.cnt};
    len_nxt = len_r;
    if (!(phase_r inside {jsu_pkg::PH_BODY, jsu_pkg::PH_ESC, jsu_pkg::PH_HEX}) &&
        !eoi && c == jsu_pkg::CH_QUOTE) begin
      len_nxt = '0;
    end else if (job.kind == jsu_pkg::KIND_BYTE && job.cnt != 2'd0) begin
      if (len_sum > {2'b00, jsu_pkg::LEN_MAX}) begin
        len_nxt = jsu_pkg::LEN_MAX;
      end else begin
        len_nxt = len_sum[jsu_pkg::LEN_W-1:0];
      end
    end
  end

  // Only words with at least one result enter the queue.
  assign push = fire && (job.cnt != 2'd0);

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_WAIT;
      cp_r    <= '0;
      hc_r    <= '0;
      len_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cp_r    <= cp_nxt;
      hc_r    <= hc_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

### rtl/jsu_queue.sv
// ============================================================================
// JSON string unescaper job queue
// Small FIFO of jobs that decouples the parser from the result sequencer.
// ============================================================================
`include "json_string_unescaper_core_macros.svh"

module jsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t wr_job,
  input  logic          pop,
  output jsu_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  jsu_pkg::job_t             mem_r [jsu_pkg::Q_DEPTH];
  logic [jsu_pkg::Q_AW-1:0]  wp_r, wp_nxt;
  logic [jsu_pkg::Q_AW-1:0]  rp_r, rp_nxt;
  logic [jsu_pkg::Q_AW:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == (jsu_pkg::Q_AW+1)'(jsu_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  // Pointer and occupancy update.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  `JSU_ASSERT_SAME(a_no_overflow, push, !full || pop, "job pushed into a full queue")
  `JSU_ASSERT_SAME(a_no_underflow, pop, !empty, "job popped from an empty queue")
  `JSU_ASSERT_SAME(a_job_has_results, push, wr_job.cnt != 2'd0, "empty job queued")
  `JSU_ASSERT_NEXT(a_count_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count did not rise")

endmodule

### rtl/jsu_back.sv
// ============================================================================
// JSON string unescaper result sequencer
// Walks the results of the job at the queue head, one result word per
// handshake, and marks the final one of each job.
// ============================================================================
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::job_t head,
  input  logic          q_empty,
  output logic          pop,
  jsu_out_if.source     out_ch
);

  logic [jsu_pkg::RES_W-1:0] idx_r, idx_nxt;
  logic                      fire;
  logic                      final_res;

  assign out_ch.valid = !q_empty;
  assign fire         = out_ch.valid && out_ch.ready;
  assign final_res    = (idx_r == head.cnt - 2'd1);
  assign pop          = fire && final_res;

  // Result word fields taken from the head job.
  assign out_ch.kind           = head.kind;
  assign out_ch.out_byte       = (head.kind == jsu_pkg::KIND_BYTE) ? head.bytes[idx_r] : 8'd0;
  assign out_ch.error_code     = head.err;
  assign out_ch.decoded_length = head.len;
  assign out_ch.last           = final_res;

  // Result index within the head job.
  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = final_res ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/json_string_unescaper_core.sv
// ============================================================================
// JSON string unescaper core
// Decodes a double-quoted JSON string, one character word in, decoded bytes,
// completion or error words out.
// ============================================================================
// The block takes one input word per clock as long as its four-entry job
// queue has room; the parser handles every word in the cycle it is taken.
// Each word yields zero to three result words, and the result side sends one
// result word per clock while the receiver is ready. Sustained throughput is
// one input word per cycle whenever the stream averages no more than one
// result per word (a six-word unicode escape gives at most three); a burst of
// multi-byte results is absorbed by the job queue, and the input side stalls
// only when that queue is full. The last flag marks the final result of each
// input word. After an error the block waits for a new opening quote, and the
// bytes already sent for that string should be discarded.
module json_string_unescaper_core (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  jsu_pkg::job_t job;
  jsu_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // Parser front end.
  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (job)
  );

  // Job queue.
  jsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (job),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Result sequencer.
  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// JSON string unescaper testbench
// Drives character words into the unescaper core, decodes the same text in a
// behavioral decoder and checks every result word in order, under random
// idling on both channels and a long result stall.
// ============================================================================
module tb_top;

  // One input word: a character or an end-of-input marker.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } char_word_t;

  // One result word as the decoder predicts it.
  typedef struct {
    jsu_pkg::kind_t kind;
    logic [7:0]     data;
    logic [2:0]     err;
    logic [15:0]    len;
    logic           last;
  } result_t;

  // Letters that follow a backslash in a simple escape.
  localparam logic [63:0] ESC_LETTERS =
    {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH, "b", "f", "n", "r", "t"};
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescaper_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Text waiting to be sent, and the decoded words still owed by the block.
  char_word_t text_q[$];
  result_t    unescaped_q[$];

  int words_queued = 0;
  int words_taken = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit in_fire = 1'b0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  // Decoder state.
  jsu_pkg::phase_t dec_phase = jsu_pkg::PH_WAIT;
  logic [15:0]     dec_code = '0;
  logic [1:0]      dec_hex_cnt = '0;
  logic [15:0]     dec_len = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder
  // ---------------------------------------------------------------------------

  function automatic int hex_nibble(input logic [7:0] c);
    if (c inside {["0":"9"]}) return int'(c - "0");
    if (c inside {["a":"f"]}) return int'(c - "a") + 10;
    if (c inside {["A":"F"]}) return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    unescaped_q.push_back('{jsu_pkg::KIND_BYTE, b, 3'd0, 16'd0, 1'b0});
    if (dec_len < jsu_pkg::LEN_MAX) dec_len++;
  endtask

  task automatic add_error(input jsu_pkg::err_t code);
    unescaped_q.push_back('{jsu_pkg::KIND_ERR, 8'd0, code, 16'd0, 1'b0});
    dec_phase = jsu_pkg::PH_WAIT;
    dec_hex_cnt = '0;
    dec_code = '0;
  endtask

  // Works out the result words caused by one accepted character word.
  task automatic unescape_char(input logic [7:0] ch, input logic eoi);
    int      before_n;
    int      nib;
    result_t tail;
    before_n = unescaped_q.size();
    case (dec_phase)
      jsu_pkg::PH_BODY: begin
        if (eoi) begin
          add_error(jsu_pkg::ERR_UNTERMINATED);
        end else if (ch == jsu_pkg::CH_QUOTE) begin
          unescaped_q.push_back('{jsu_pkg::KIND_DONE, 8'd0, 3'd0, dec_len, 1'b0});
          dec_phase = jsu_pkg::PH_WAIT;
        end else if (ch == jsu_pkg::CH_BACKSLASH) begin
          dec_phase = jsu_pkg::PH_ESC;
        end else begin
          add_byte(ch);
        end
      end
      jsu_pkg::PH_ESC: begin
        if (eoi) begin
          add_error(jsu_pkg::ERR_BAD_ESCAPE);
        end else begin
          dec_phase = jsu_pkg::PH_BODY;
          case (ch)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: add_byte(ch);
            "b": add_byte(8'h08);
            "f": add_byte(8'h0C);
            "n": add_byte(8'h0A);
            "r": add_byte(8'h0D);
            "t": add_byte(8'h09);
            jsu_pkg::CH_LOWER_U: begin
              dec_phase = jsu_pkg::PH_HEX;
              dec_hex_cnt = '0;
              dec_code = '0;
            end
            default: add_error(jsu_pkg::ERR_BAD_ESCAPE);
          endcase
        end
      end
      jsu_pkg::PH_HEX: begin
        nib = hex_nibble(ch);
        if (eoi) begin
          add_error(jsu_pkg::ERR_SHORT_UNI);
        end else if (nib < 0) begin
          add_error(jsu_pkg::ERR_BAD_HEX);
        end else begin
          dec_code = {dec_code[11:0], 4'(nib)};
          if (dec_hex_cnt < 2'd3) begin
            dec_hex_cnt++;
          end else begin
            // Fourth digit: emit the code point as UTF-8.
            dec_hex_cnt = '0;
            dec_phase = jsu_pkg::PH_BODY;
            if (dec_code < jsu_pkg::UTF8_ONE_LIMIT) begin
              add_byte(dec_code[7:0]);
            end else if (dec_code < jsu_pkg::UTF8_TWO_LIMIT) begin
              add_byte(jsu_pkg::UTF8_LEAD2 | {3'b0, dec_code[10:6]});
              add_byte(jsu_pkg::UTF8_CONT | {2'b0, dec_code[5:0] & jsu_pkg::UTF8_MASK});
            end else begin
              add_byte(jsu_pkg::UTF8_LEAD3 | {4'b0, dec_code[15:12]});
              add_byte(jsu_pkg::UTF8_CONT | {2'b0, dec_code[11:6]});
              add_byte(jsu_pkg::UTF8_CONT | {2'b0, dec_code[5:0] & jsu_pkg::UTF8_MASK});
            end
            dec_code = '0;
          end
        end
      end
      default: begin
        if (!eoi && ch == jsu_pkg::CH_QUOTE) begin
          dec_phase = jsu_pkg::PH_BODY;
          dec_len = '0;
          dec_hex_cnt = '0;
          dec_code = '0;
        end else begin
          add_error(jsu_pkg::ERR_NO_QUOTE);
        end
      end
    endcase
    // The final word of this character carries the last flag.
    if (unescaped_q.size() > before_n) begin
      tail = unescaped_q.pop_back();
      tail.last = 1'b1;
      unescaped_q.push_back(tail);
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next character word at the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    char_word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = text_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.in_byte <= w.ch;
        in_if.end_of_input <= w.eoi;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted character, checks each result word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    in_fire = rst_n && in_if.valid && in_if.ready;
    if (in_fire) begin
      unescape_char(in_if.in_byte, in_if.end_of_input);
      words_taken++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (unescaped_q.size() == 0) begin
        $error("result word with nothing expected: kind %0d byte %0h",
               out_if.kind, out_if.out_byte);
        fail_count++;
      end else begin
        want = unescaped_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_if.kind));
        check_field("out_byte", 16'(want.data), 16'(out_if.out_byte));
        check_field("error_code", 16'(want.err), 16'(out_if.error_code));
        check_field("decoded_length", want.len, out_if.decoded_length);
        check_field("last", 16'(want.last), 16'(out_if.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic put_char(input logic [7:0] c);
    text_q.push_back('{c, 1'b0});
    words_queued++;
  endtask

  // The character field is don't-care with end of input, so it is random.
  task automatic put_end();
    text_q.push_back('{8'($urandom_range(255)), 1'b1});
    words_queued++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return ($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
    return c;
  endfunction

  task automatic put_unicode(input logic [15:0] cp);
    put_char(jsu_pkg::CH_BACKSLASH);
    put_char(jsu_pkg::CH_LOWER_U);
    for (int i = 3; i >= 0; i--) put_char(hex_char(cp[4*i +: 4]));
  endtask

  // A mostly well-formed string with random content, an occasional broken
  // ending, or a stray word between strings.
  task automatic put_random_string();
    int         n;
    int         pick;
    logic [7:0] c;
    logic [15:0] cp;
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1)) put_end();
      else put_char(8'($urandom_range(255)));
    end else begin
      put_char(jsu_pkg::CH_QUOTE);
      n = $urandom_range(8);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          put_char(plain_char());
        end else if (pick < 80) begin
          put_char(jsu_pkg::CH_BACKSLASH);
          put_char(ESC_LETTERS[8*$urandom_range(7) +: 8]);
        end else begin
          // Spread code points over the one, two and three byte forms.
          case ($urandom_range(2))
            0: cp = 16'($urandom_range(16'h007F));
            1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
            default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
          endcase
          put_unicode(cp);
        end
      end
      if ($urandom_range(99) < 75) begin
        put_char(jsu_pkg::CH_QUOTE);
      end else begin
        case ($urandom_range(4))
          0: put_end();
          1: begin
            put_char(jsu_pkg::CH_BACKSLASH);
            put_end();
          end
          2: begin
            do c = 8'($urandom_range(255));
            while (c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH,
                             jsu_pkg::CH_LOWER_U, "b", "f", "n", "r", "t"});
            put_char(jsu_pkg::CH_BACKSLASH);
            put_char(c);
          end
          3: begin
            put_char(jsu_pkg::CH_BACKSLASH);
            put_char(jsu_pkg::CH_LOWER_U);
            repeat ($urandom_range(3)) put_char(hex_char(4'($urandom_range(15))));
            put_end();
          end
          default: begin
            put_char(jsu_pkg::CH_BACKSLASH);
            put_char(jsu_pkg::CH_LOWER_U);
            repeat ($urandom_range(3)) put_char(hex_char(4'($urandom_range(15))));
            if ($urandom_range(1)) begin
              c = jsu_pkg::CH_QUOTE;
            end else begin
              do c = 8'($urandom_range(255));
              while (c inside {["0":"9"], ["A":"F"], ["a":"f"]});
            end
            put_char(c);
          end
        endcase
      end
    end
  endtask

  // Holds the sender back until every queued word is in and decoded.
  task automatic drain();
    while (words_taken != words_queued || unescaped_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    int target;
    send_pcts = '{0, 56, 0, 17};
    recv_pcts = '{0, 0, 56, 17};
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: stray byte and end while waiting, every simple escape,
    // a zero code point and the largest one, then each broken ending.
    put_char("x");
    put_end();
    put_text("\"\\b\\f\\n\\r\\t\\\"\\\\\\/\\u0000\\uFfFf\"");
    put_text("\"\\");
    put_end();
    put_text("\"\\q");
    put_text("\"\\u1");
    put_end();
    put_text("\"\\u\"");
    put_text("\"a");
    put_end();
    drain();

    // Random strings under each idling mix.
    for (int p = 0; p < 4; p++) begin
      send_pcts[p] = send_pcts[p];
      send_idle_pct = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      target = words_queued + 80;
      while (words_queued < target) put_random_string();
      drain();
    end

    // Long receiver hold-off while three-byte escapes keep arriving.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = ~hold_req;
    put_char(jsu_pkg::CH_QUOTE);
    repeat (6) put_unicode(16'($urandom_range(16'hFFFF, 16'h0800)));
    put_char(jsu_pkg::CH_QUOTE);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### json_string_unescaper_core.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_channels.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescaper_core.sv
dv/tb_top.sv
